### rtl/pit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants for the pulse interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam logic [7:0] SyncByte       = 8'hF0;
  localparam logic [7:0] TimeoutDefault = 8'hFF;

  localparam int unsigned IntervalWidth = 24;

  typedef logic [IntervalWidth-1:0] interval_t;
  typedef logic [7:0]               frame_byte_t;

  // Request kinds
  typedef enum logic {
    REQ_OVERFLOW = 1'b0,
    REQ_CAPTURE  = 1'b1
  } req_kind_e;

  // Position of a byte within the outgoing frame
  typedef enum logic [1:0] {
    POS_SYNC = 2'd0,
    POS_HIGH = 2'd1,
    POS_MID  = 2'd2,
    POS_LOW  = 2'd3
  } frame_pos_e;

  // Push request from the front end into the interval queue
  typedef struct packed {
    logic      valid;
    interval_t interval;
  } push_req_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    interval_t interval;
  } queue_head_t;

  function automatic frame_byte_t interval_byte(interval_t iv, frame_pos_e pos);
    frame_byte_t b;
    b = SyncByte;
    case (pos)
      POS_HIGH: b = iv[23:16];
      POS_MID:  b = iv[15:8];
      POS_LOW:  b = iv[7:0];
      default:  b = SyncByte;
    endcase
    return b;
  endfunction

endpackage

### rtl/pit_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_intf
// Channel interfaces: event requests, frame bytes and configuration writes.
// ----------------------------------------------------------------------------
interface pit_evt_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] capture_time;

  modport source (output valid, req_type, capture_time, input ready);
  modport sink   (input valid, req_type, capture_time, output ready);
endinterface

interface pit_frm_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface pit_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] timeout_overflows;

  modport source (output valid, timeout_overflows, input ready);
  modport sink   (input valid, timeout_overflows, output ready);
endinterface

### rtl/pulse_interval_timer_unit.sv
`timescale 1ns / 1ps
// A stop capture is pushed into the interval queue; when idle, its sync byte is then
// loaded into the output register. Throughput: one event request per cycle; 4-byte frames.
// Requests stall only while the interval queue (QueueDepth entries) is full.
// Reset: asynchronous, active low; disarms, clears count and start time,
//   timeout register returns to 255, queue and output stage empty.
// ----------------------------------------------------------------------------
// pulse_interval_timer_unit
// Capture-to-capture interval timer on a free-running 16-bit timer,
// reporting each interval as a framed byte stream.
// ----------------------------------------------------------------------------
module pulse_interval_timer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pit_evt_if.sink   evt_i,
  pit_cfg_if.sink   cfg_i,
  pit_frm_if.source frm_o
);
  import pit_pkg::*;

  push_req_t   push;
  queue_head_t head;
  logic        q_full;
  logic        pop;

  pit_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  pit_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (q_full)
  );

  pit_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .frm_o  (frm_o)
  );

endmodule

### rtl/pit_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_front
// Accepts overflow/capture requests, tracks the measurement state and
// pushes each finished interval into the queue.
// ----------------------------------------------------------------------------
module pit_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  pit_evt_if.sink            evt_i,
  pit_cfg_if.sink            cfg_i,
  input  logic               q_full_i,
  output pit_pkg::push_req_t push_o
);
  import pit_pkg::*;

  logic        armed_q, armed_d;
  logic [15:0] start_q, start_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  timeout_q;
  logic [7:0]  count_inc;
  logic        evt_fire;
  interval_t   interval;

  assign evt_i.ready = ~q_full_i;
  assign cfg_i.ready = 1'b1;
  assign evt_fire    = evt_i.valid & evt_i.ready;

  assign count_inc = count_q + 8'd1;
  assign interval  = {count_q, evt_i.capture_time} - {8'd0, start_q};

  always_comb begin
    armed_d         = armed_q;
    start_d         = start_q;
    count_d         = count_q;
    push_o.valid    = 1'b0;
    push_o.interval = interval;
    if (evt_fire) begin
      if (req_kind_e'(evt_i.req_type) == REQ_OVERFLOW) begin
        if (armed_q) begin
          if (count_inc == timeout_q) begin
            armed_d = 1'b0;
            count_d = 8'd0;
          end else begin
            count_d = count_inc;
          end
        end
      end else if (!armed_q) begin
        start_d = evt_i.capture_time;
        count_d = 8'd0;
        armed_d = 1'b1;
      end else begin
        push_o.valid = 1'b1;
        armed_d      = 1'b0;
        count_d      = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      start_q   <= 16'd0;
      count_q   <= 8'd0;
      timeout_q <= TimeoutDefault;
    end else begin
      armed_q <= armed_d;
      start_q <= start_d;
      count_q <= count_d;
      if (cfg_i.valid) begin
        timeout_q <= cfg_i.timeout_overflows;
      end
    end
  end

endmodule

### rtl/pit_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_queue
// Small FIFO of finished intervals between the front and back ends.
// ----------------------------------------------------------------------------
module pit_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pit_pkg::push_req_t   push_i,
  input  logic                 pop_i,
  output pit_pkg::queue_head_t head_o,
  output logic                 full_o
);
  import pit_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  interval_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o          = (count_q == FullCnt);
  assign head_o.valid    = (count_q != '0);
  assign head_o.interval = mem_q[rd_ptr_q];

  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.interval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/pit_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_back
// Serializes each queued interval into a four-byte frame through a
// registered output stage.
// ----------------------------------------------------------------------------
module pit_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pit_pkg::queue_head_t head_i,
  output logic                 pop_o,
  pit_frm_if.source            frm_o
);
  import pit_pkg::*;

  logic        out_valid_q;
  frame_byte_t out_byte_q;
  logic        out_last_q;
  logic        busy_q;
  frame_pos_e  pos_q;
  interval_t   iv_q;
  logic        advance;

  assign frm_o.valid    = out_valid_q;
  assign frm_o.out_byte = out_byte_q;
  assign frm_o.last     = out_last_q;

  // output register is free when empty or being taken this cycle
  assign advance = ~out_valid_q | frm_o.ready;
  assign pop_o   = advance & ~busy_q & head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_byte_q  <= SyncByte;
      out_last_q  <= 1'b0;
      busy_q      <= 1'b0;
      pos_q       <= POS_SYNC;
      iv_q        <= '0;
    end else if (advance) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= interval_byte(iv_q, pos_q);
        out_last_q  <= (pos_q == POS_LOW);
        if (pos_q == POS_LOW) begin
          busy_q <= 1'b0;
          pos_q  <= POS_SYNC;
        end else begin
          pos_q <= frame_pos_e'(pos_q + 2'd1);
        end
      end else if (head_i.valid) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= SyncByte;
        out_last_q  <= 1'b0;
        iv_q        <= head_i.interval;
        busy_q      <= 1'b1;
        pos_q       <= POS_HIGH;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
